[hdl/wrpd_pkg.sv]
// Package for the weighted RMS pose distance block.
// Holds shared widths, state encodings and the coordinate difference helper.
// Used by wrpd_mul, wrpd_divsqrt and weighted_rms_pose_distance.
package wrpd_pkg;

	localparam int COORD_W = 24;          // signed Q15.8 coordinate
	localparam int MAG_W   = 24;          // magnitude of a coordinate difference
	localparam int WGT_W   = 16;          // unsigned Q4.12 weight
	localparam int MUL_W   = 25;          // operand width of the shared multiplier
	localparam int PROD_W  = 2 * MUL_W;   // product width
	localparam int SQ_W    = 50;          // sum of three squares, Q.16
	localparam int ACC_W   = 64;          // saturating accumulator, Q.28
	localparam int ERR_W   = 28;          // Q20.8 error
	localparam int ROOT_W  = 26;          // integer square root of a 52-bit value
	localparam int MEAN_SH = 12;          // Q.28 mean to Q.16 radicand
	localparam int REM_S_W = ROOT_W + 2;  // square root partial remainder
	localparam int STEP_W  = 6;

	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(ACC_W - 1);
	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_SQX  = 10'b00_0000_0010,
		ST_SQY  = 10'b00_0000_0100,
		ST_SQZ  = 10'b00_0000_1000,
		ST_SUM  = 10'b00_0001_0000,
		ST_WLO  = 10'b00_0010_0000,
		ST_WHI  = 10'b00_0100_0000,
		ST_ACC  = 10'b00_1000_0000,
		ST_DGO  = 10'b01_0000_0000,
		ST_FIN  = 10'b10_0000_0000
	} seq_state_t;

	typedef enum logic [2:0] {
		DS_IDLE = 3'b001,
		DS_DIV  = 3'b010,
		DS_SQRT = 3'b100
	} ds_state_t;

	// |a - b| of two signed coordinates; fits in MAG_W bits.
	function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
	                                              input logic [COORD_W-1:0] b);
		logic [COORD_W:0] d;
		logic [COORD_W:0] n;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		n = -d;
		return d[COORD_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
	endfunction

endpackage

[hdl/weighted_rms_pose_distance.sv]
// Weighted RMS pose distance: saturating weighted sum of squared point distances,
// mean over the point count, square root, and running worst error.
// An item without last uses the shared multiplier five times (three squares, two weight
// halves), then makes two saturating accumulator adds; the next item waits until these are
// done. An item with last then runs the 64-step divider and 26-step square root before its
// result is valid and the next item accepted; a held result stalls the input until it leaves.
// Reset (arst_n low) clears the accumulator, point count, worst error and output valid.
module weighted_rms_pose_distance #(
	parameter int MAX_POINTS = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [wrpd_pkg::COORD_W-1:0] new_x,
	input  logic [wrpd_pkg::COORD_W-1:0] new_y,
	input  logic [wrpd_pkg::COORD_W-1:0] new_z,
	input  logic [wrpd_pkg::COORD_W-1:0] old_x,
	input  logic [wrpd_pkg::COORD_W-1:0] old_y,
	input  logic [wrpd_pkg::COORD_W-1:0] old_z,
	input  logic [wrpd_pkg::WGT_W-1:0]   weight,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [wrpd_pkg::ERR_W-1:0]   rms_error,
	output logic [wrpd_pkg::ERR_W-1:0]   worst_error
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int HI_W  = wrpd_pkg::PROD_W + wrpd_pkg::MUL_W;

	wrpd_pkg::seq_state_t             state_q;
	logic [wrpd_pkg::MAG_W-1:0]       mx_q, my_q, mz_q;
	logic [wrpd_pkg::WGT_W-1:0]       w_q;
	logic                             last_q;
	logic [wrpd_pkg::SQ_W-1:0]        sq_q;
	logic [wrpd_pkg::ACC_W-1:0]       acc_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [wrpd_pkg::ERR_W-1:0]       worst_q;
	logic                             out_valid_q;
	logic [wrpd_pkg::ERR_W-1:0]       rms_q;
	logic [wrpd_pkg::ERR_W-1:0]       worst_out_q;

	logic [wrpd_pkg::MUL_W-1:0]       mul_a, mul_b;
	logic [wrpd_pkg::PROD_W-1:0]      mul_p;
	logic [wrpd_pkg::ACC_W:0]         add_lo;
	logic [HI_W-1:0]                  hi_sh;
	logic [wrpd_pkg::ACC_W:0]         add_hi;
	logic                             ds_start;
	logic                             ds_busy;
	logic [wrpd_pkg::ROOT_W-1:0]      ds_root;
	logic [wrpd_pkg::ERR_W-1:0]       rms_new;
	logic [wrpd_pkg::ERR_W-1:0]       worst_new;
	logic                             out_load;
	logic                             accept;

	assign accept = in_valid && in_ready;

	always_comb begin
		unique case (state_q)
			wrpd_pkg::ST_SQX: begin
				mul_a = wrpd_pkg::MUL_W'(mx_q);
				mul_b = wrpd_pkg::MUL_W'(mx_q);
			end
			wrpd_pkg::ST_SQY: begin
				mul_a = wrpd_pkg::MUL_W'(my_q);
				mul_b = wrpd_pkg::MUL_W'(my_q);
			end
			wrpd_pkg::ST_SQZ: begin
				mul_a = wrpd_pkg::MUL_W'(mz_q);
				mul_b = wrpd_pkg::MUL_W'(mz_q);
			end
			wrpd_pkg::ST_WLO: begin
				mul_a = sq_q[wrpd_pkg::MUL_W-1:0];
				mul_b = wrpd_pkg::MUL_W'(w_q);
			end
			wrpd_pkg::ST_WHI: begin
				mul_a = sq_q[wrpd_pkg::SQ_W-1:wrpd_pkg::MUL_W];
				mul_b = wrpd_pkg::MUL_W'(w_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	wrpd_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// Saturation is monotone, so adding the two partial products one after
	// the other gives the same result as saturating the full product first.
	always_comb begin
		add_lo = {1'b0, acc_q} + (wrpd_pkg::ACC_W + 1)'(mul_p);
		hi_sh  = {mul_p, {wrpd_pkg::MUL_W{1'b0}}};
		add_hi = {1'b0, acc_q} + {1'b0, hi_sh[wrpd_pkg::ACC_W-1:0]};
	end

	wrpd_divsqrt #(
		.CNT_W (CNT_W)
	) u_divsqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ds_start),
		.dividend (acc_q),
		.divisor  (cnt_q),
		.busy     (ds_busy),
		.root     (ds_root)
	);

	assign ds_start  = (state_q == wrpd_pkg::ST_DGO);
	assign rms_new   = wrpd_pkg::ERR_W'(ds_root);
	assign worst_new = (rms_new > worst_q) ? rms_new : worst_q;
	assign out_load  = (state_q == wrpd_pkg::ST_FIN) && !ds_busy
	                   && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wrpd_pkg::ST_IDLE;
			acc_q       <= '0;
			cnt_q       <= '0;
			worst_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				worst_q     <= worst_new;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				wrpd_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= wrpd_pkg::ST_SQX;
					end
				end
				wrpd_pkg::ST_SQX: state_q <= wrpd_pkg::ST_SQY;
				wrpd_pkg::ST_SQY: state_q <= wrpd_pkg::ST_SQZ;
				wrpd_pkg::ST_SQZ: state_q <= wrpd_pkg::ST_SUM;
				wrpd_pkg::ST_SUM: state_q <= wrpd_pkg::ST_WLO;
				wrpd_pkg::ST_WLO: state_q <= wrpd_pkg::ST_WHI;
				wrpd_pkg::ST_WHI: begin
					acc_q   <= add_lo[wrpd_pkg::ACC_W] ? '1 : add_lo[wrpd_pkg::ACC_W-1:0];
					state_q <= wrpd_pkg::ST_ACC;
				end
				wrpd_pkg::ST_ACC: begin
					if ((|hi_sh[HI_W-1:wrpd_pkg::ACC_W]) || add_hi[wrpd_pkg::ACC_W]) begin
						acc_q <= '1;
					end else begin
						acc_q <= add_hi[wrpd_pkg::ACC_W-1:0];
					end
					if (cnt_q < CNT_W'(MAX_POINTS)) begin
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= last_q ? wrpd_pkg::ST_DGO : wrpd_pkg::ST_IDLE;
				end
				wrpd_pkg::ST_DGO: begin
					// divider has captured sum and count; clear for the next comparison
					acc_q   <= '0;
					cnt_q   <= '0;
					state_q <= wrpd_pkg::ST_FIN;
				end
				wrpd_pkg::ST_FIN: begin
					if (out_load) begin
						state_q <= wrpd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= wrpd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mx_q   <= wrpd_pkg::abs_diff(new_x, old_x);
			my_q   <= wrpd_pkg::abs_diff(new_y, old_y);
			mz_q   <= wrpd_pkg::abs_diff(new_z, old_z);
			w_q    <= weight;
			last_q <= last;
		end
		unique case (state_q)
			wrpd_pkg::ST_SQY: sq_q <= mul_p;
			wrpd_pkg::ST_SQZ,
			wrpd_pkg::ST_SUM: sq_q <= sq_q + mul_p;
			default:          sq_q <= sq_q;
		endcase
		if (out_load) begin
			rms_q       <= rms_new;
			worst_out_q <= worst_new;
		end
	end

	assign in_ready    = (state_q == wrpd_pkg::ST_IDLE);
	assign out_valid   = out_valid_q;
	assign rms_error   = rms_q;
	assign worst_error = worst_out_q;

endmodule

[hdl/wrpd_mul.sv]
// Shared unsigned multiplier with a registered product.
// Depends on wrpd_pkg for operand and product widths.
module wrpd_mul (
	input  logic                       clk,
	input  logic [wrpd_pkg::MUL_W-1:0]  a,
	input  logic [wrpd_pkg::MUL_W-1:0]  b,
	output logic [wrpd_pkg::PROD_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= wrpd_pkg::PROD_W'(a) * wrpd_pkg::PROD_W'(b);
	end

endmodule

[hdl/wrpd_divsqrt.sv]
// Iterative divider (one quotient bit a cycle) followed by an integer square root
// (one root bit a cycle), both on a single shared compare-subtract. Uses wrpd_pkg.
module wrpd_divsqrt #(
	parameter int CNT_W = 13
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wrpd_pkg::ACC_W-1:0]  dividend,
	input  logic [CNT_W-1:0]            divisor,
	output logic                        busy,
	output logic [wrpd_pkg::ROOT_W-1:0] root
);

	localparam int SQ_OP_W = wrpd_pkg::REM_S_W + 2;
	localparam int SW      = (CNT_W + 1 > SQ_OP_W) ? CNT_W + 1 : SQ_OP_W;

	wrpd_pkg::ds_state_t              state_q;
	logic [wrpd_pkg::STEP_W-1:0]      step_q;
	logic [wrpd_pkg::ACC_W-1:0]       dq_q;
	logic [CNT_W-1:0]                 divisor_q;
	logic [CNT_W-1:0]                 rem_d_q;
	logic [wrpd_pkg::REM_S_W-1:0]     rem_s_q;
	logic [wrpd_pkg::ROOT_W-1:0]      root_q;

	logic [CNT_W:0]   t_div;
	logic [SW-1:0]    sub_a;
	logic [SW-1:0]    sub_b;
	logic [SW:0]      diff;
	logic             ge;

	always_comb begin
		t_div = {rem_d_q, dq_q[wrpd_pkg::ACC_W-1]};
		if (state_q == wrpd_pkg::DS_SQRT) begin
			sub_a = SW'({rem_s_q, dq_q[wrpd_pkg::ACC_W-1 -: 2]});
			sub_b = SW'({root_q, 2'b01});
		end else begin
			sub_a = SW'(t_div);
			sub_b = SW'(divisor_q);
		end
		diff = {1'b0, sub_a} - {1'b0, sub_b};
		ge   = ~diff[SW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wrpd_pkg::DS_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				wrpd_pkg::DS_IDLE: begin
					if (start) begin
						state_q <= wrpd_pkg::DS_DIV;
						step_q  <= wrpd_pkg::DIV_LAST;
					end
				end
				wrpd_pkg::DS_DIV: begin
					if (step_q == '0) begin
						state_q <= wrpd_pkg::DS_SQRT;
						step_q  <= wrpd_pkg::SQRT_LAST;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				wrpd_pkg::DS_SQRT: begin
					if (step_q == '0) begin
						state_q <= wrpd_pkg::DS_IDLE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				default: begin
					state_q <= wrpd_pkg::DS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			wrpd_pkg::DS_IDLE: begin
				if (start) begin
					dq_q      <= dividend;
					divisor_q <= divisor;
					rem_d_q   <= '0;
					rem_s_q   <= '0;
					root_q    <= '0;
				end
			end
			wrpd_pkg::DS_DIV: begin
				// shift the dividend out, the quotient in
				rem_d_q <= ge ? diff[CNT_W-1:0] : t_div[CNT_W-1:0];
				dq_q    <= {dq_q[wrpd_pkg::ACC_W-2:0], ge};
			end
			wrpd_pkg::DS_SQRT: begin
				// radicand is quotient >> 12: its top 26 bit pairs
				rem_s_q <= ge ? diff[wrpd_pkg::REM_S_W-1:0] : sub_a[wrpd_pkg::REM_S_W-1:0];
				root_q  <= {root_q[wrpd_pkg::ROOT_W-2:0], ge};
				dq_q    <= {dq_q[wrpd_pkg::ACC_W-3:0], 2'b00};
			end
			default: begin
				dq_q <= dq_q;
			end
		endcase
	end

	assign busy = (state_q != wrpd_pkg::DS_IDLE);
	assign root = root_q;

endmodule
